/* design/irpde_pkg.sv */
// Package holding the shared types, constants and functions of the pulse-distance encoder.
`default_nettype none
package irpde_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned PREFIX_W     = 16;
   localparam int unsigned SHIFT_W      = PREFIX_W + BYTE_W;
   localparam int unsigned COUNT_W      = $clog2(SHIFT_W + 1);
   localparam int unsigned CSR_INDEX_W  = 3;

   localparam logic [PREFIX_W-1:0]   PREFIX_BITS    = {PREFIX_W{1'b1}};
   localparam logic [COUNT_W-1:0]    COUNT_WITH_HDR = COUNT_W'(SHIFT_W);
   localparam logic [COUNT_W-1:0]    COUNT_PLAIN    = COUNT_W'(BYTE_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_GAP        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT1_SPACE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT0_SPACE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LSB_FIRST  = 3'd4;

   localparam logic [WORD_W-1:0] GAP_RESET        = 32'h0001_0000;
   localparam logic [WORD_W-1:0] PULSE_RESET      = 32'h0100_0400;
   localparam logic [WORD_W-1:0] BIT1_SPACE_RESET = 32'h0000_0C00;
   localparam logic [WORD_W-1:0] BIT0_SPACE_RESET = 32'h0000_0800;

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              starts_code;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] timing_word;
      logic              last_of_run;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      WSEL_GAP   = 2'd0,
      WSEL_PULSE = 2'd1,
      WSEL_SPACE = 2'd2
   } word_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      logic         shift;
      logic         last;
      word_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic done;
   } dp_status_type;

   function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] result;
      for (int i = 0; i < BYTE_W; i++) begin
         result[i] = value[BYTE_W-1-i];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

/* design/irpde_ctrl.sv */
// Controller state machine that sequences the header, space and pulse words.
`default_nettype none
module irpde_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     starts_code,
   output logic                    req_stall,
   input  irpde_pkg::dp_status_type status,
   output irpde_pkg::dp_cmd_type    cmd
);
   import irpde_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_GAP    = 5'b00010,
      ST_HPULSE = 5'b00100,
      ST_SPACE  = 5'b01000,
      ST_PULSE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = WSEL_PULSE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = starts_code ? ST_GAP : ST_SPACE;
            end
         end
         ST_GAP: begin
            cmd.sel = WSEL_GAP;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_HPULSE;
            end
         end
         ST_HPULSE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SPACE;
            end
         end
         ST_SPACE: begin
            cmd.sel = WSEL_SPACE;
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.shift = 1'b1;
               state_in  = ST_PULSE;
            end
         end
         ST_PULSE: begin
            cmd.last = status.done;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.done ? ST_IDLE : ST_SPACE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* design/irpde_dp.sv */
// Datapath with the timing registers, the bit shifter and the output register.
`default_nettype none
module irpde_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire [irpde_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [irpde_pkg::WORD_W-1:0]          csr_wdata,
   input  irpde_pkg::req_payload_type           req_payload,
   input  irpde_pkg::dp_cmd_type                cmd,
   output irpde_pkg::dp_status_type             status,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output irpde_pkg::rsp_payload_type           rsp_payload
);
   import irpde_pkg::*;

   logic [WORD_W-1:0]  gap_ff;
   logic [WORD_W-1:0]  pulse_ff;
   logic [WORD_W-1:0]  bit1_space_ff;
   logic [WORD_W-1:0]  bit0_space_ff;
   logic               lsb_first_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] shift_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_data_ff;
   rsp_payload_type    rsp_data_in;
   logic [BYTE_W-1:0]  ordered_byte;
   logic [WORD_W-1:0]  word_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff        <= GAP_RESET;
         pulse_ff      <= PULSE_RESET;
         bit1_space_ff <= BIT1_SPACE_RESET;
         bit0_space_ff <= BIT0_SPACE_RESET;
         lsb_first_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP:        gap_ff        <= csr_wdata;
            CSR_PULSE:      pulse_ff      <= csr_wdata;
            CSR_BIT1_SPACE: bit1_space_ff <= csr_wdata;
            CSR_BIT0_SPACE: bit0_space_ff <= csr_wdata;
            CSR_LSB_FIRST:  lsb_first_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign ordered_byte = lsb_first_ff ? reverse_byte(req_payload.code_byte)
                                      : req_payload.code_byte;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (cmd.load) begin
         if (req_payload.starts_code) begin
            shift_in = {PREFIX_BITS, ordered_byte};
            count_in = COUNT_WITH_HDR;
         end else begin
            shift_in = {ordered_byte, {PREFIX_W{1'b0}}};
            count_in = COUNT_PLAIN;
         end
      end else if (cmd.shift) begin
         shift_in = {shift_ff[SHIFT_W-2:0], 1'b0};
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      unique case (cmd.sel)
         WSEL_GAP:   word_sel = gap_ff;
         WSEL_SPACE: word_sel = shift_ff[SHIFT_W-1] ? bit1_space_ff : bit0_space_ff;
         default:    word_sel = pulse_ff;
      endcase
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.done     = (count_ff == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.timing_word = word_sel;
         rsp_data_in.last_of_run = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

/* design/ir_pulse_distance_encoder_top.sv */
// Top level of the pulse-distance infrared encoder.
// Each accepted item is one code byte; it yields 16 timing words, or 50 when it starts a code
// (gap, pulse and a 16-bit all-ones prefix first). One word leaves per cycle while the output
// is not stalled, and the controller takes a new item only from its idle state, so a byte
// waits until every word of the one before has entered the single output register that the
// word sequencer feeds. The last word of each item carries last_of_run. Timing registers are
// written through the csr port, by the user only while the block is idle (not enforced).
`default_nettype none
module ir_pulse_distance_encoder_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire [irpde_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [irpde_pkg::WORD_W-1:0]      csr_wdata,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  irpde_pkg::req_payload_type       req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output irpde_pkg::rsp_payload_type       rsp_payload
);
   import irpde_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   irpde_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .starts_code (req_payload.starts_code),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   irpde_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* design/irpde_checker.sv */
// Port-level checker for the encoder and the bind that attaches it to the top level.
`default_nettype none
module irpde_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input irpde_pkg::rsp_payload_type       rsp_payload
);
   import irpde_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result item changed or vanished.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input taken again straight after an item was accepted.");

   a_mid_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_of_run |-> req_stall)
      else $error("Input open while a run is still being delivered.");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Block not idle and empty after reset.");

endmodule

bind ir_pulse_distance_encoder_top irpde_checker u_irpde_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

/* verif/irpde_timing_check.sv */
// Checker that predicts the timing words of the pulse-distance encoder and compares the results.
`default_nettype none
module irpde_timing_check (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire [irpde_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [irpde_pkg::WORD_W-1:0]         csr_wdata,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  irpde_pkg::req_payload_type          req_payload,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  irpde_pkg::rsp_payload_type          rsp_payload,
   output int                                  mismatch_count,
   output int                                  words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import irpde_pkg::*;

   localparam logic [BYTE_W-1:0] PREFIX_BYTE  = 8'hFF;
   localparam int                PREFIX_BYTES = PREFIX_W / BYTE_W;

   logic [WORD_W-1:0] gap_timing;
   logic [WORD_W-1:0] pulse_timing;
   logic [WORD_W-1:0] one_timing;
   logic [WORD_W-1:0] zero_timing;
   logic              lsb_order;
   logic [WORD_W-1:0] run_words[$];
   rsp_payload_type   expected_words[$];

   function void append_byte_words(input logic [BYTE_W-1:0] value);
      int pos;
      for (int i = 0; i < BYTE_W; i++) begin
         pos = lsb_order ? i : BYTE_W - 1 - i;
         run_words.push_back(value[pos] ? one_timing : zero_timing);
         run_words.push_back(pulse_timing);
      end
   endfunction

   function void predict_timing_words(input req_payload_type item);
      run_words.delete();
      if (item.starts_code) begin
         run_words.push_back(gap_timing);
         run_words.push_back(pulse_timing);
         for (int p = 0; p < PREFIX_BYTES; p++) begin
            append_byte_words(PREFIX_BYTE);
         end
      end
      append_byte_words(item.code_byte);
      foreach (run_words[i]) begin
         expected_words.push_back(rsp_payload_type'{timing_word: run_words[i],
                                                    last_of_run: (i == run_words.size() - 1)});
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
      $display("%0t ns: %s: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         gap_timing     = GAP_RESET;
         pulse_timing   = PULSE_RESET;
         one_timing     = BIT1_SPACE_RESET;
         zero_timing    = BIT0_SPACE_RESET;
         lsb_order      = 1'b0;
         mismatch_count = 0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAP:        gap_timing  = csr_wdata;
               CSR_PULSE:      pulse_timing = csr_wdata;
               CSR_BIT1_SPACE: one_timing  = csr_wdata;
               CSR_BIT0_SPACE: zero_timing = csr_wdata;
               CSR_LSB_FIRST:  lsb_order   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_timing_words(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_words.size() == 0) begin
               report_mismatch("timing word with no item waiting", '0, got.timing_word);
            end else begin
               want = expected_words.pop_front();
               if (got.timing_word !== want.timing_word) begin
                  report_mismatch("timing_word", want.timing_word, got.timing_word);
               end
               if (got.last_of_run !== want.last_of_run) begin
                  report_mismatch("last_of_run", WORD_W'(want.last_of_run),
                                  WORD_W'(got.last_of_run));
               end
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule
`default_nettype wire

/* verif/tb_ir_pulse_distance_encoder_top.sv */
// Testbench top that drives code bytes and timing settings into the encoder and gives the verdict.
`default_nettype none
module tb_ir_pulse_distance_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import irpde_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int SETTLE_CYCLES   = 60;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_LSB_FIRST + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = {CSR_INDEX_W{1'b1}};

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   int                     cycle_count = 0;
   int                     mismatch_count;
   int                     words_pending;

   ir_pulse_distance_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   irpde_timing_check u_timing_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] code, input logic starts);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req_payload_type'{code_byte: code, starts_code: starts};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_timing(input logic [WORD_W-1:0] gap, input logic [WORD_W-1:0] pulse,
                                 input logic [WORD_W-1:0] bit1_space,
                                 input logic [WORD_W-1:0] bit0_space,
                                 input logic [WORD_W-1:0] order);
      wait_idle();
      write_csr(CSR_GAP, gap);
      write_csr(CSR_PULSE, pulse);
      write_csr(CSR_BIT1_SPACE, bit1_space);
      write_csr(CSR_BIT0_SPACE, bit0_space);
      write_csr(CSR_LSB_FIRST, order);
      // A write beyond the register list must leave every setting alone.
      write_csr(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)), $urandom());
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_chance);
      send_idle_pct = idle_pct;
      stall_pct     = stall_chance;
      repeat (ITEMS_PER_PHASE) begin
         if ($urandom_range(0, 99) < 3) begin
            wait_idle();
         end
         send_item(BYTE_W'($urandom()), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      stall_pct     = 47;
      send_item(8'hA5, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h3C, 1'b1);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);

      // Extreme timing words; the order register gets an all-ones word, of which only bit 0 counts.
      program_timing('0, '1, '0, '1, '1);
      send_item(8'h01, 1'b1);
      send_item(8'h80, 1'b0);
      send_item(8'h5A, 1'b0);
      wait_idle();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'hC3, 1'b0);

      program_timing($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      run_random_phase(10, 47);

      program_timing('1, '0, '1, '0, 32'hFFFF_FFFE);
      run_random_phase(47, 10);

      program_timing($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      run_random_phase(0, 0);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
